/* hdl/dmrs_pkg.sv */
`timescale 1ns / 1ps

package dmrs_pkg;

   // sample precision: signed fixed point with SAMPLE_BITS-1 fraction bits
   localparam int SAMPLE_BITS = 24;
   localparam int FRAC_BITS   = SAMPLE_BITS - 1;
   localparam int SMP_W       = SAMPLE_BITS + 1;   // holds exactly +-1.0
   localparam int DEC_W       = SAMPLE_BITS + 3;   // holds +-4.0 after float decode
   localparam int MIX_W       = DEC_W + 1;
   localparam int DIFF_W      = SMP_W + 1;
   localparam int RAW_W       = 32;

   // read position, unsigned with 24 fraction bits
   localparam int OFS_FRAC    = 24;
   localparam int OFS_W       = 30;
   localparam int RATIO_W     = 28;
   localparam int MUL_OFS_W   = OFS_FRAC + 1;      // offset is at most 1.0 inside the loop
   localparam int PROD_W      = MUL_OFS_W + 1 + DIFF_W;
   localparam int STEP_W      = PROD_W - OFS_FRAC;

   localparam logic [OFS_W-1:0] ONE_OFS = OFS_W'(1) << OFS_FRAC;
   localparam logic signed [SMP_W-1:0] ONE_SAMPLE = SMP_W'(1) << FRAC_BITS;
   localparam logic [DEC_W-2:0] FLOAT_LIMIT = (DEC_W-1)'(1) << (FRAC_BITS + 2);

   localparam int DEFAULT_MAX_RUN = 64;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO_MIX    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_RATIO    = 2'd2;

   localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(1) << OFS_FRAC;

   typedef enum logic [1:0] {
      FMT_FLOAT32 = 2'd0,
      FMT_PCM16   = 2'd1,
      FMT_PCM24   = 2'd2,
      FMT_PCM32   = 2'd3
   } fmt_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEC_L,
      ST_DEC_R,
      ST_TEST,
      ST_MUL,
      ST_ROUND,
      ST_EMIT,
      ST_FINISH
   } state_type;

   // request to the shared interpolation multiplier
   typedef struct packed {
      logic                     load;
      logic [MUL_OFS_W-1:0]     offset;
      logic signed [DIFF_W-1:0] diff;
   } mul_req_type;

endpackage

/* hdl/dmrs_decode.sv */
`timescale 1ns / 1ps

module dmrs_decode import dmrs_pkg::*; (
   input  fmt_type                  fmt,
   input  logic [RAW_W-1:0]         word,
   output logic signed [DEC_W-1:0]  value
);

   logic [7:0]               ex_raw;
   logic [7:0]               ex_eff;
   logic [23:0]              mant;
   logic [4:0]               rs;
   logic [24:0]              rnd_sum;
   logic [DEC_W-2:0]         mag;
   logic signed [DEC_W-1:0]  fval;
   logic [RAW_W:0]           p32;

   always_comb begin
      ex_raw  = word[30:23];
      ex_eff  = (ex_raw == 8'd0) ? 8'd1 : ex_raw;
      mant    = {(ex_raw != 8'd0), word[22:0]};
      rs      = 5'd0;
      rnd_sum = '0;
      if (ex_raw == 8'hFF) begin
         mag = '0;                                 // nan and infinity
      end else if (ex_eff >= 8'd129) begin
         mag = FLOAT_LIMIT;                        // saturate at 4.0
      end else if (ex_eff == 8'd128) begin
         mag = {1'b0, mant, 1'b0};
      end else if (ex_eff == 8'd127) begin
         mag = {2'b00, mant};
      end else if (ex_eff >= 8'd103) begin
         // right shift by 1..24, halves away from zero on the magnitude
         rs      = 5'(8'd127 - ex_eff);
         rnd_sum = {1'b0, mant} + (25'd1 << (rs - 5'd1));
         mag     = {1'b0, rnd_sum >> rs};
      end else begin
         mag = '0;
      end
      fval = word[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      p32  = {word[31], word} + 33'd128;

      unique case (fmt)
         FMT_FLOAT32: value = fval;
         FMT_PCM16:   value = {{3{word[15]}}, word[15:0], 8'd0};
         FMT_PCM24:   value = {{3{word[23]}}, word[23:0]};
         FMT_PCM32:   value = {{2{p32[RAW_W]}}, p32[RAW_W:8]};
         default:     value = '0;
      endcase
   end

endmodule

/* hdl/dmrs_interp.sv */
`timescale 1ns / 1ps

module dmrs_interp import dmrs_pkg::*; (
   input  logic                     clock,
   input  mul_req_type              mul_req,
   input  logic signed [SMP_W-1:0]  prev_sample,
   output logic signed [SMP_W-1:0]  interp_sample
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] rnd;
   logic signed [STEP_W-1:0] step;
   logic signed [STEP_W-1:0] sum;

   always_comb begin
      prod_in = mul_req.load ? $signed({1'b0, mul_req.offset}) * mul_req.diff : prod_ff;
      // round to nearest, halves toward plus infinity
      rnd     = prod_ff + $signed(PROD_W'(1) << (OFS_FRAC - 1));
      step    = rnd[PROD_W-1:OFS_FRAC];
      sum     = STEP_W'(prev_sample) + step;
      interp_sample = sum[SMP_W-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

/* hdl/pcm_downmix_linear_resampler_top.sv */
`timescale 1ns / 1ps

// Mono downmixing linear-interpolation resampler. Each req transaction carries one audio
// frame (two raw channel words plus silent and restart flags); the block decodes the words
// as float32, pcm16, pcm24 or pcm32 into signed Q1.23, averages them when stereo_mix is set,
// clamps to +-1.0 and then produces zero to MAX_RUN rsp transactions of interpolated
// samples, the final one of a frame flagged by rsp_last. The first frame after reset or a
// restart comes out unchanged as a single transaction. Configuration must be written
// through the csr port while the block is idle (0 sample_format, 1 stereo_mix, 2
// step_ratio); the block itself does not enforce this. One frame is handled at a time
// and req_stall stays high until it is finished. A frame passes accept, left decode,
// right decode and mix and the interpolation test, then multiply, round and hand over
// for each output sample, which rsp_stall can hold, then a last state that updates the
// read position; a run's first frame goes from the test to hand-over and back to idle.

module pcm_downmix_linear_resampler_top import dmrs_pkg::*; #(
   parameter int MAX_RUN = DEFAULT_MAX_RUN
) (
   input  logic                     clock,
   input  logic                     reset,
   // input frames
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [RAW_W-1:0]         req_left_raw,
   input  logic [RAW_W-1:0]         req_right_raw,
   input  logic                     req_silent,
   input  logic                     req_restart,
   // output samples
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [SMP_W-1:0]  rsp_out_sample,
   output logic                     rsp_last,
   // configuration
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [RATIO_W-1:0]       csr_wdata
);

   localparam int CNT_W = $clog2(MAX_RUN);

   // control
   state_type            state_ff,     state_in;
   fmt_type              fmt_ff,       fmt_in;
   logic                 stereo_ff,    stereo_in;
   logic [RATIO_W-1:0]   ratio_ff,     ratio_in;
   logic                 have_prev_ff, have_prev_in;
   logic                 first_ff,     first_in;
   logic [CNT_W-1:0]     cnt_ff,       cnt_in;
   logic [OFS_W-1:0]     ofs_ff,       ofs_in;
   logic signed [SMP_W-1:0] prev_ff,   prev_in;

   // payload
   logic [RAW_W-1:0]        left_ff,   left_in;
   logic [RAW_W-1:0]        right_ff,  right_in;
   logic                    silent_ff, silent_in;
   logic signed [DEC_W-1:0] acc_ff,    acc_in;
   logic signed [SMP_W-1:0] sample_ff, sample_in;
   logic signed [SMP_W-1:0] out_ff,    out_in;
   logic                    last_ff,   last_in;

   logic [RAW_W-1:0]        dec_word;
   logic signed [DEC_W-1:0] dec_value;
   logic signed [MIX_W-1:0] mix_sum;
   logic signed [DEC_W-1:0] mixed;
   logic [OFS_W-1:0]        ofs_next;
   logic signed [SMP_W-1:0] interp_sample;
   mul_req_type             mul_req;

   // one decoder, used for the left word then the right word
   dmrs_decode u_decode (
      .fmt   (fmt_ff),
      .word  (dec_word),
      .value (dec_value)
   );

   // shared multiplier with registered product and rounding
   dmrs_interp u_interp (
      .clock         (clock),
      .mul_req       (mul_req),
      .prev_sample   (prev_ff),
      .interp_sample (interp_sample)
   );

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_EMIT);
   assign rsp_out_sample = out_ff;
   assign rsp_last       = last_ff;

   assign dec_word = (state_ff == ST_DEC_R) ? right_ff : left_ff;

   always_comb begin
      mul_req.load   = (state_ff == ST_MUL);
      mul_req.offset = ofs_ff[MUL_OFS_W-1:0];
      mul_req.diff   = DIFF_W'(sample_ff) - DIFF_W'(prev_ff);
   end

   always_comb begin
      state_in     = state_ff;
      fmt_in       = fmt_ff;
      stereo_in    = stereo_ff;
      ratio_in     = ratio_ff;
      have_prev_in = have_prev_ff;
      first_in     = first_ff;
      cnt_in       = cnt_ff;
      ofs_in       = ofs_ff;
      prev_in      = prev_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      silent_in    = silent_ff;
      acc_in       = acc_ff;
      sample_in    = sample_ff;
      out_in       = out_ff;
      last_in      = last_ff;

      // average rounds toward minus infinity, then clamp to +-1.0
      mix_sum  = stereo_ff ? (MIX_W'(acc_ff) + MIX_W'(dec_value)) : (MIX_W'(acc_ff) <<< 1);
      mixed    = mix_sum[MIX_W-1:1];
      ofs_next = ofs_ff + OFS_W'(ratio_ff);

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SAMPLE_FORMAT: fmt_in    = fmt_type'(csr_wdata[1:0]);
            CSR_STEREO_MIX:    stereo_in = csr_wdata[0];
            CSR_STEP_RATIO:    ratio_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               left_in   = req_left_raw;
               right_in  = req_right_raw;
               silent_in = req_silent;
               cnt_in    = '0;
               first_in  = 1'b0;
               if (req_restart) begin
                  have_prev_in = 1'b0;
               end
               state_in = ST_DEC_L;
            end
         end
         ST_DEC_L: begin
            acc_in   = dec_value;
            state_in = ST_DEC_R;
         end
         ST_DEC_R: begin
            if (silent_ff) begin
               sample_in = '0;
            end else if (mixed > DEC_W'(ONE_SAMPLE)) begin
               sample_in = ONE_SAMPLE;
            end else if (mixed < -DEC_W'(ONE_SAMPLE)) begin
               sample_in = -ONE_SAMPLE;
            end else begin
               sample_in = mixed[SMP_W-1:0];
            end
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (!have_prev_ff) begin
               // first frame of a run passes straight through
               have_prev_in = 1'b1;
               prev_in      = sample_ff;
               ofs_in       = OFS_W'(ratio_ff);
               out_in       = sample_ff;
               last_in      = 1'b1;
               first_in     = 1'b1;
               state_in     = ST_EMIT;
            end else if (ofs_ff <= ONE_OFS) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MUL: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            out_in   = interp_sample;
            last_in  = (ofs_next > ONE_OFS) || (cnt_ff == CNT_W'(MAX_RUN - 1));
            ofs_in   = ofs_next;
            cnt_in   = cnt_ff + CNT_W'(1);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               if (!last_ff) begin
                  state_in = ST_MUL;
               end else if (first_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            // a run cut short by the cap drops the rest of the segment
            ofs_in   = (ofs_ff <= ONE_OFS) ? '0 : (ofs_ff - ONE_OFS);
            prev_in  = sample_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fmt_ff       <= FMT_PCM16;
         stereo_ff    <= 1'b1;
         ratio_ff     <= RATIO_RESET;
         have_prev_ff <= 1'b0;
         first_ff     <= 1'b0;
         cnt_ff       <= '0;
         ofs_ff       <= '0;
         prev_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         fmt_ff       <= fmt_in;
         stereo_ff    <= stereo_in;
         ratio_ff     <= ratio_in;
         have_prev_ff <= have_prev_in;
         first_ff     <= first_in;
         cnt_ff       <= cnt_in;
         ofs_ff       <= ofs_in;
         prev_ff      <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff   <= left_in;
      right_ff  <= right_in;
      silent_ff <= silent_in;
      acc_ff    <= acc_in;
      sample_ff <= sample_in;
      out_ff    <= out_in;
      last_ff   <= last_in;
   end

   // a frame is taken only one at a time
   a_one_frame: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("frame accepted while another is in progress");

   // interpolated samples never leave the clamped range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_sample <= ONE_SAMPLE) && (rsp_out_sample >= -ONE_SAMPLE))
      else $error("output sample outside +-1.0");

   // the final sample of a frame is not followed straight away by another
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last |=> !rsp_valid)
      else $error("output after final transaction of a frame");

   // the first frame of a run yields exactly one flagged sample
   a_first_direct: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST) && !have_prev_ff |=> rsp_valid && rsp_last)
      else $error("first frame not passed through");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import dmrs_pkg::*;

   // timing of the bench
   localparam int CLK_HALF         = 6;
   localparam int RESET_CYCLES     = 12;
   localparam int SETTLE_CYCLES    = 16;     // covers a frame that emits nothing
   localparam int TAIL_CYCLES      = 24;
   localparam int HOLD_CYCLES      = 300;    // long receiver hold-off
   localparam int WATCHDOG_LIMIT   = 4000;   // cycles with no transaction at all
   localparam int MAX_REPORTS      = 100;

   // size of the run
   localparam int N_ROWS           = 25;
   localparam int RAND_ITEMS       = 128;
   localparam int PHASE_ITEMS      = 16;
   localparam int HOLD_PHASE       = 2;

   localparam logic [RATIO_W-1:0] RATIO_MIN  = 28'd270000;
   localparam logic [RATIO_W-1:0] RATIO_MAX  = 28'hFFF_FFFF;
   localparam logic [RATIO_W-1:0] RATIO_FILL = 28'h040_0000;   // four outputs per frame

   localparam longint ONE_LONG  = longint'(1) << FRAC_BITS;
   localparam longint FLOAT_CAP = longint'(1) << (FRAC_BITS + 2);

   // one interpolated sample as it leaves the block
   typedef struct {
      logic signed [SMP_W-1:0] smp;
      logic                    last;
   } sample_type;

   // one row of the directed table
   typedef struct {
      fmt_type                 fmt;
      logic                    stereo;
      logic [RATIO_W-1:0]      ratio;
      logic [RAW_W-1:0]        left;
      logic [RAW_W-1:0]        right;
      logic                    silent;
      logic                    restart;
      logic                    typed;     // expected sample written in the row
      logic signed [SMP_W-1:0] want;
   } frame_row_type;

   // dut ports
   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [RAW_W-1:0]        req_left_raw;
   logic [RAW_W-1:0]        req_right_raw;
   logic                    req_silent;
   logic                    req_restart;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [SMP_W-1:0] rsp_out_sample;
   logic                    rsp_last;
   logic                    csr_write_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [RATIO_W-1:0]      csr_wdata;

   // predictor copy of the registers, at their reset values
   fmt_type            cfg_fmt    = FMT_PCM16;
   logic               cfg_stereo = 1'b1;
   logic [RATIO_W-1:0] cfg_ratio  = RATIO_RESET;

   // predictor copy of the interpolator state
   logic               have_prev = 1'b0;
   longint             prev_smp  = 0;
   logic [OFS_W-1:0]   rd_pos    = '0;

   // samples still owed by the block, oldest first
   sample_type         pending_samples[$];

   frame_row_type      rows [N_ROWS];

   int                 err_count    = 0;
   int                 quiet_cycles = 0;
   bit                 gap_en       = 1'b1;   // sender may idle between transactions
   bit                 stall_en     = 1'b1;   // receiver may stall in bursts
   bit                 hold_pending = 1'b0;   // request for the long hold-off

   pcm_downmix_linear_resampler_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_left_raw   (req_left_raw),
      .req_right_raw  (req_right_raw),
      .req_silent     (req_silent),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_sample (rsp_out_sample),
      .rsp_last       (rsp_last),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // decode one channel word into signed q1.23 (float saturates to +-4.0)
   function automatic longint channel_to_q23(logic [RAW_W-1:0] w, fmt_type f);
      longint          v;
      longint          mag;
      longint unsigned mant;
      int              ex;
      int              sh;
      case (f)
         FMT_FLOAT32: begin
            ex   = int'(w[30:23]);
            mant = w[22:0];
            // nan and infinity carry no sample
            if (ex == 255) return 0;
            // denormals keep their value, normals gain the hidden bit
            if (ex == 0) ex = 1;
            else mant = mant | (64'd1 << 23);
            sh = ex - 150 + FRAC_BITS;
            if (sh >= 40) mag = FLOAT_CAP;
            else if (sh >= 0) mag = longint'(mant << sh);
            else if (sh <= -40) mag = 0;
            // magnitude rounded, halves away from zero
            else mag = longint'((mant + (64'd1 << (-sh - 1))) >> (-sh));
            if (mag > FLOAT_CAP) mag = FLOAT_CAP;
            return w[31] ? -mag : mag;
         end
         FMT_PCM16: begin
            v = longint'($signed(w[15:0]));
            return v << (FRAC_BITS - 15);
         end
         FMT_PCM24: begin
            return longint'($signed(w[23:0]));
         end
         default: begin
            // pcm32: round to nearest, halves towards plus infinity
            v = longint'($signed(w));
            return (v + (longint'(1) << (30 - FRAC_BITS))) >>> (31 - FRAC_BITS);
         end
      endcase
   endfunction

   // work out the samples that one accepted frame causes and update the state
   function automatic void resample_frame(logic [RAW_W-1:0] l, logic [RAW_W-1:0] r,
                                          logic sil, logic rst, bit keep);
      longint     s;
      longint     prod;
      longint     o;
      int         n;
      sample_type run[$];
      s = 0;
      n = 0;
      if (rst) have_prev = 1'b0;
      if (!sil) begin
         s = channel_to_q23(l, cfg_fmt);
         // average rounds towards minus infinity
         if (cfg_stereo) s = (s + channel_to_q23(r, cfg_fmt)) >>> 1;
         if (s > ONE_LONG) s = ONE_LONG;
         if (s < -ONE_LONG) s = -ONE_LONG;
      end
      if (!have_prev) begin
         // first frame goes straight through
         have_prev = 1'b1;
         prev_smp  = s;
         rd_pos    = OFS_W'(cfg_ratio);
         run.push_back('{smp: SMP_W'(s), last: 1'b1});
      end else begin
         while (rd_pos <= ONE_OFS && n < DEFAULT_MAX_RUN) begin
            prod = longint'(rd_pos) * (s - prev_smp);
            o    = prev_smp + ((prod + (longint'(1) << (OFS_FRAC - 1))) >>> OFS_FRAC);
            run.push_back('{smp: SMP_W'(o), last: 1'b0});
            n++;
            rd_pos = rd_pos + OFS_W'(cfg_ratio);
         end
         // a capped segment drops its remaining positions
         if (rd_pos <= ONE_OFS) rd_pos = '0;
         else rd_pos = rd_pos - ONE_OFS;
         prev_smp = s;
         if (n > 0) run[n-1].last = 1'b1;
      end
      if (keep) foreach (run[i]) pending_samples.push_back(run[i]);
   endfunction

   // random channel word, biased towards the interesting codes of the format
   function automatic logic [RAW_W-1:0] random_word(fmt_type f);
      logic [RAW_W-1:0] w;
      int               k;
      bit               neg;
      w   = $urandom;
      k   = $urandom_range(0, 7);
      neg = (k == 1);
      if (f == FMT_FLOAT32) begin
         case (k)
            0:       ;
            1:       w[30:23] = 8'hFF;
            2:       w[30:23] = 8'h00;
            default: w[30:23] = 8'($urandom_range(96, 130));
         endcase
      end else if (k < 2) begin
         // full-scale codes, unused upper bits left random
         case (f)
            FMT_PCM16: w[15:0] = neg ? 16'h8000 : 16'h7FFF;
            FMT_PCM24: w[23:0] = neg ? 24'h80_0000 : 24'h7F_FFFF;
            default:   w       = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         endcase
      end
      return w;
   endfunction

   task automatic report_mismatch(string msg);
      err_count++;
      if (err_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // offer one frame and hold it until the block takes the transaction
   task automatic offer_frame(logic [RAW_W-1:0] l, logic [RAW_W-1:0] r, logic sil,
                              logic rst, bit typed, logic signed [SMP_W-1:0] want);
      req_valid     <= 1'b1;
      req_left_raw  <= l;
      req_right_raw <= r;
      req_silent    <= sil;
      req_restart   <= rst;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      // predictor always advances; a typed row supplies its own expectation
      resample_frame(l, r, sil, rst, !typed);
      if (typed) pending_samples.push_back('{smp: want, last: 1'b1});
      if (gap_en && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // drain the block, then write all three registers
   task automatic set_mode(fmt_type f, logic st, logic [RATIO_W-1:0] ratio);
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_SAMPLE_FORMAT;
      csr_wdata    <= RATIO_W'(f);
      @(posedge clock);
      csr_index    <= CSR_STEREO_MIX;
      csr_wdata    <= RATIO_W'(st);
      @(posedge clock);
      csr_index    <= CSR_STEP_RATIO;
      csr_wdata    <= ratio;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_fmt    = f;
      cfg_stereo = st;
      cfg_ratio  = ratio;
   endtask

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin : rsp_pacing
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (stall_en && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result checking and watchdog, on values sampled at the edge
   always @(posedge clock) begin : sample_check
      sample_type exp_s;
      bit         rsp_taken;
      rsp_taken = !reset && rsp_valid === 1'b1 && rsp_stall === 1'b0;
      if (rsp_taken) begin
         if (pending_samples.size() == 0) begin
            report_mismatch($sformatf("unexpected sample %0d last %0b",
                                      rsp_out_sample, rsp_last));
         end else begin
            exp_s = pending_samples.pop_front();
            if (rsp_out_sample !== exp_s.smp)
               report_mismatch($sformatf("out_sample %0d, expected %0d",
                                         rsp_out_sample, exp_s.smp));
            if (rsp_last !== exp_s.last)
               report_mismatch($sformatf("last %0b, expected %0b (sample %0d)",
                                         rsp_last, exp_s.last, exp_s.smp));
         end
      end
      if (!reset) begin
         if (rsp_taken || (req_valid === 1'b1 && req_stall === 1'b0)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles, %0d samples owed",
                     $realtime, WATCHDOG_LIMIT, pending_samples.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int                 rand_items;
      int                 phase;
      bit                 idle_ok;
      fmt_type            f;
      logic               st;
      logic [RATIO_W-1:0] ratio;
      logic [RAW_W-1:0]   l;
      logic [RAW_W-1:0]   r;
      logic               sil;
      logic               rst;

      // every input known from the first step
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_left_raw  <= '0;
      req_right_raw <= '0;
      req_silent    <= 1'b0;
      req_restart   <= 1'b0;
      csr_write_en  <= 1'b0;
      csr_index     <= CSR_SAMPLE_FORMAT;
      csr_wdata     <= '0;

      // directed table: fmt, stereo, ratio, left, right, silent, restart, typed, want
      // first frame after reset with the reset settings
      rows[0]  = '{FMT_PCM16, 1'b1, RATIO_RESET, 32'h0000_7FFF, 32'h0000_7FFF,
                   1'b0, 1'b0, 1'b1, 25'sd8388352};
      // pcm16 negative full scale, upper bits ignored
      rows[1]  = '{FMT_PCM16, 1'b1, RATIO_RESET, 32'hFFFF_8000, 32'h1234_8000,
                   1'b0, 1'b0, 1'b0, '0};
      // opposite extremes averaged
      rows[2]  = '{FMT_PCM16, 1'b1, RATIO_RESET, 32'h0000_8000, 32'h0000_7FFF,
                   1'b0, 1'b0, 1'b0, '0};
      // silent frame ignores its words
      rows[3]  = '{FMT_PCM16, 1'b1, RATIO_RESET, 32'hDEAD_BEEF, 32'hCAFE_F00D,
                   1'b1, 1'b0, 1'b0, '0};
      // pcm24 positive full scale on restart, left only
      rows[4]  = '{FMT_PCM24, 1'b0, RATIO_RESET, 32'hFF7F_FFFF, 32'h0000_0000,
                   1'b0, 1'b1, 1'b1, 25'sd8388607};
      rows[5]  = '{FMT_PCM24, 1'b0, RATIO_RESET, 32'h0080_0000, 32'hFFFF_FFFF,
                   1'b0, 1'b0, 1'b0, '0};
      // pcm32 positive full scale rounds up to exactly one
      rows[6]  = '{FMT_PCM32, 1'b0, RATIO_RESET, 32'h7FFF_FFFF, 32'h0000_0000,
                   1'b0, 1'b1, 1'b1, 25'sd8388608};
      rows[7]  = '{FMT_PCM32, 1'b0, RATIO_RESET, 32'h8000_0000, 32'h0000_0000,
                   1'b0, 1'b0, 1'b0, '0};
      // pcm32 halves go towards plus infinity
      rows[8]  = '{FMT_PCM32, 1'b0, RATIO_RESET, 32'h0000_0080, 32'h0000_0000,
                   1'b0, 1'b0, 1'b0, '0};
      rows[9]  = '{FMT_PCM32, 1'b0, RATIO_RESET, 32'hFFFF_FF80, 32'h0000_0000,
                   1'b0, 1'b0, 1'b0, '0};
      rows[10] = '{FMT_PCM32, 1'b1, RATIO_RESET, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   1'b0, 1'b1, 1'b1, 25'sd8388608};
      // float one on restart
      rows[11] = '{FMT_FLOAT32, 1'b0, RATIO_RESET, 32'h3F80_0000, 32'h0000_0000,
                   1'b0, 1'b1, 1'b1, 25'sd8388608};
      // infinity and nan decode to zero
      rows[12] = '{FMT_FLOAT32, 1'b0, RATIO_RESET, 32'h7F80_0000, 32'h0000_0000,
                   1'b0, 1'b0, 1'b0, '0};
      rows[13] = '{FMT_FLOAT32, 1'b0, RATIO_RESET, 32'hFFC0_0001, 32'h0000_0000,
                   1'b0, 1'b0, 1'b0, '0};
      // half an lsb rounds away from zero either sign
      rows[14] = '{FMT_FLOAT32, 1'b0, RATIO_RESET, 32'h3380_0000, 32'h0000_0000,
                   1'b0, 1'b0, 1'b0, '0};
      rows[15] = '{FMT_FLOAT32, 1'b0, RATIO_RESET, 32'hB380_0000, 32'h0000_0000,
                   1'b0, 1'b0, 1'b0, '0};
      // denormal
      rows[16] = '{FMT_FLOAT32, 1'b0, RATIO_RESET, 32'h0000_0001, 32'h0000_0000,
                   1'b0, 1'b0, 1'b0, '0};
      // largest finite float saturates, then the mix clamps
      rows[17] = '{FMT_FLOAT32, 1'b1, RATIO_RESET, 32'h7F7F_FFFF, 32'h3F80_0000,
                   1'b0, 1'b0, 1'b0, '0};
      rows[18] = '{FMT_FLOAT32, 1'b1, RATIO_RESET, 32'h4080_0000, 32'hC080_0000,
                   1'b0, 1'b0, 1'b0, '0};
      // minus eight saturates to minus four, clamps to minus one
      rows[19] = '{FMT_FLOAT32, 1'b1, RATIO_RESET, 32'hC100_0000, 32'h0000_0000,
                   1'b0, 1'b1, 1'b1, -25'sd8388608};
      // smallest ratio: long runs of outputs
      rows[20] = '{FMT_PCM16, 1'b0, RATIO_MIN, 32'h0000_7FFF, 32'h0000_0000,
                   1'b0, 1'b1, 1'b1, 25'sd8388352};
      rows[21] = '{FMT_PCM16, 1'b0, RATIO_MIN, 32'h0000_8000, 32'h0000_0000,
                   1'b0, 1'b0, 1'b0, '0};
      // largest ratio: frames with no output
      rows[22] = '{FMT_PCM16, 1'b0, RATIO_MAX, 32'h0000_1234, 32'h0000_0000,
                   1'b0, 1'b1, 1'b1, 25'sd1192960};
      rows[23] = '{FMT_PCM16, 1'b0, RATIO_MAX, 32'h0000_4321, 32'h0000_0000,
                   1'b0, 1'b0, 1'b0, '0};
      rows[24] = '{FMT_PCM16, 1'b0, RATIO_MAX, 32'h0000_8000, 32'h0000_0000,
                   1'b0, 1'b0, 1'b0, '0};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, registers rewritten only when a row changes them
      foreach (rows[i]) begin
         if (rows[i].fmt != cfg_fmt || rows[i].stereo != cfg_stereo ||
             rows[i].ratio != cfg_ratio)
            set_mode(rows[i].fmt, rows[i].stereo, rows[i].ratio);
         offer_frame(rows[i].left, rows[i].right, rows[i].silent, rows[i].restart,
                     rows[i].typed, rows[i].want);
      end

      // random part in phases, each with its own settings
      rand_items = 0;
      phase      = 0;
      while (rand_items < RAND_ITEMS) begin
         f  = fmt_type'($urandom_range(0, 3));
         st = $urandom_range(0, 1);
         case ($urandom_range(0, 9))
            0:       ratio = RATIO_MIN;
            1:       ratio = RATIO_MAX;
            2:       ratio = RATIO_W'($urandom_range(RATIO_MIN, 28'h03F_FFFF));
            3:       ratio = RATIO_W'($urandom_range(28'h200_0000, RATIO_MAX));
            default: ratio = RATIO_W'($urandom_range(28'h060_0000, 28'h1C0_0000));
         endcase
         // the hold-off phase uses a short ratio so the block backs up quickly
         if (phase == HOLD_PHASE) ratio = RATIO_FILL;
         set_mode(f, st, ratio);
         // no idling in the closing stretch
         idle_ok  = rand_items < RAND_ITEMS - 2 * PHASE_ITEMS;
         gap_en   = idle_ok && $urandom_range(0, 3) != 0;
         stall_en = idle_ok && $urandom_range(0, 3) != 0;
         if (phase == HOLD_PHASE) hold_pending = 1'b1;
         repeat (PHASE_ITEMS) begin
            l   = random_word(f);
            r   = random_word(f);
            sil = $urandom_range(0, 15) == 0;
            rst = $urandom_range(0, 15) == 0;
            offer_frame(l, r, sil, rst, 1'b0, '0);
            rand_items++;
         end
         phase++;
      end

      // wait for the owed samples, then a quiet tail for strays
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0 && pending_samples.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
